>>> design/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; the decode, emit and top design files import this package.
package u8u16_pkg;

    localparam logic [1:0] KIND_UNIT   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
    localparam logic [7:0] LEAD2_CODE = 8'b1100_0000;
    localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
    localparam logic [7:0] LEAD3_CODE = 8'b1110_0000;
    localparam logic [7:0] LEAD4_MASK = 8'b1111_1000;
    localparam logic [7:0] LEAD4_CODE = 8'b1111_0000;
    localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
    localparam logic [7:0] CONT_CODE  = 8'b1000_0000;

    localparam logic [15:0] SURR_HIGH = 16'hd800;
    localparam logic [15:0] SURR_LOW  = 16'hdc00;

    localparam int unsigned MAX_RESULTS = 3;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  kind;
    } t_result;

    typedef struct packed {
        logic [1:0]                    count;
        t_result [MAX_RESULTS-1:0]     res;
    } t_decode_out;

endpackage

>>> design/u8u16_in_if.sv
// Byte input channel of the UTF-8 to UTF-16 decoder.
// Standalone; carries valid, ready and one UTF-8 byte with its end flag.
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

>>> design/u8u16_out_if.sv
// Result output channel of the UTF-8 to UTF-16 decoder.
// Standalone; carries valid, ready and one UTF-16 result.
interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic [1:0]  kind;
    logic        last;

    modport source (output valid, output code_unit, output kind, output last, input ready);
    modport sink (input valid, input code_unit, input kind, input last, output ready);
endinterface

>>> design/u8u16_decode.sv
// Sequence state and per-byte decode logic of the UTF-8 to UTF-16 decoder.
// Depends on u8u16_pkg.
module u8u16_decode (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic [7:0]               i_byte,
    input  logic                     i_eos,
    output u8u16_pkg::t_decode_out   o_res
);
    import u8u16_pkg::*;

    logic [1:0]  r_bytes_rem, n_bytes_rem;
    logic [2:0]  r_seq_len, n_seq_len;
    logic [20:0] r_bits, n_bits;
    logic        r_err, n_err;

    logic [3:0]  plane;
    logic [1:0]  cnt;
    t_decode_out res;

    always_comb begin
        n_bytes_rem = r_bytes_rem;
        n_seq_len   = r_seq_len;
        n_bits      = r_bits;
        n_err       = r_err;
        cnt         = 2'd0;
        res         = '0;
        plane       = '0;

        if (r_bytes_rem != 2'd0) begin
            if ((i_byte & CONT_MASK) == CONT_CODE) begin
                n_bits      = {r_bits[14:0], i_byte[5:0]};
                n_bytes_rem = r_bytes_rem - 2'd1;
                if (n_bytes_rem == 2'd0) begin
                    if (r_seq_len == 3'd4) begin
                        // Plane field is the code point's top bits minus one, modulo 16.
                        plane = 4'(n_bits[20:16] - 5'd1);
                        res.res[0].code_unit = {6'd0, plane, n_bits[15:10]} + SURR_HIGH;
                        res.res[0].kind      = KIND_UNIT;
                        res.res[1].code_unit = {6'd0, n_bits[9:0]} + SURR_LOW;
                        res.res[1].kind      = KIND_UNIT;
                        cnt = 2'd2;
                    end else begin
                        res.res[0].code_unit = n_bits[15:0];
                        res.res[0].kind      = KIND_UNIT;
                        cnt = 2'd1;
                    end
                    n_seq_len = 3'd0;
                    n_bits    = '0;
                end
            end else begin
                n_err       = 1'b1;
                n_bytes_rem = 2'd0;
                n_seq_len   = 3'd0;
                n_bits      = '0;
            end
        end else if (i_byte[7] == 1'b0) begin
            res.res[0].code_unit = {8'd0, i_byte};
            res.res[0].kind      = KIND_UNIT;
            cnt = 2'd1;
        end else if ((i_byte & LEAD2_MASK) == LEAD2_CODE) begin
            n_bits      = {16'd0, i_byte[4:0]};
            n_seq_len   = 3'd2;
            n_bytes_rem = 2'd1;
        end else if ((i_byte & LEAD3_MASK) == LEAD3_CODE) begin
            n_bits      = {17'd0, i_byte[3:0]};
            n_seq_len   = 3'd3;
            n_bytes_rem = 2'd2;
        end else if ((i_byte & LEAD4_MASK) == LEAD4_CODE) begin
            n_bits      = {18'd0, i_byte[2:0]};
            n_seq_len   = 3'd4;
            n_bytes_rem = 2'd3;
        end

        if (i_eos) begin
            if (n_bytes_rem != 2'd0) begin
                n_err = 1'b1;
            end
            res.res[cnt].code_unit = 16'd0;
            res.res[cnt].kind      = n_err ? KIND_REJECT : KIND_ACCEPT;
            cnt = cnt + 2'd1;
            n_bytes_rem = 2'd0;
            n_seq_len   = 3'd0;
            n_bits      = '0;
            n_err       = 1'b0;
        end
        res.count = cnt;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_rem <= '0;
            r_seq_len   <= '0;
            r_bits      <= '0;
            r_err       <= 1'b0;
        end else if (i_fire) begin
            r_bytes_rem <= n_bytes_rem;
            r_seq_len   <= n_seq_len;
            r_bits      <= n_bits;
            r_err       <= n_err;
        end
    end

endmodule

>>> design/u8u16_emit.sv
// Result buffer of the UTF-8 to UTF-16 decoder: holds the results of one byte
// and hands them out one transfer at a time. Depends on u8u16_pkg.
module u8u16_emit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  u8u16_pkg::t_decode_out  i_res,
    input  logic                    i_out_ready,
    output logic                    o_can_load,
    output logic                    o_valid,
    output u8u16_pkg::t_result      o_result,
    output logic                    o_last
);
    import u8u16_pkg::*;

    t_result [MAX_RESULTS-1:0] r_buf, n_buf;
    logic [1:0]                r_cnt, n_cnt;
    logic                      pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_result   = r_buf[0];
    assign o_last     = (r_cnt == 2'd1);
    assign pop        = o_valid && i_out_ready;
    // A new byte may enter once the last pending result leaves in this cycle.
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_out_ready);

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (i_load) begin
            n_buf = i_res.res;
            n_cnt = i_res.count;
        end else if (pop) begin
            n_buf = {r_buf[2], r_buf[2], r_buf[1]};
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> design/utf8_to_utf16_decoder_top.sv
// UTF-8 to UTF-16 decoder. One byte transfer is taken per cycle while the result buffer
// can load; its results (up to three: a code unit or surrogate pair, then an end marker
// on the final byte) appear in the cycle after the byte is taken and leave one per output
// transfer. The input takes a new byte in the same cycle that the last pending result of
// the previous byte is transferred, so throughput is one byte per cycle except that a byte
// with two or three results holds the input while the result buffer drains, and output
// back-pressure also holds it. Depends on u8u16_pkg and the two channel interfaces.
module utf8_to_utf16_decoder_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    u8u16_in_if.sink       i_in,
    u8u16_out_if.source    o_out
);
    import u8u16_pkg::*;

    logic        fire;
    logic        can_load;
    t_decode_out dec_res;
    t_result     out_res;
    logic        out_valid;
    logic        out_last;

    assign i_in.ready = can_load;
    assign fire       = i_in.valid && can_load;

    u8u16_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (i_in.in_byte),
        .i_eos   (i_in.end_of_string),
        .o_res   (dec_res)
    );

    u8u16_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_res       (dec_res),
        .i_out_ready (o_out.ready),
        .o_can_load  (can_load),
        .o_valid     (out_valid),
        .o_result    (out_res),
        .o_last      (out_last)
    );

    assign o_out.valid     = out_valid;
    assign o_out.code_unit = out_res.code_unit;
    assign o_out.kind      = out_res.kind;
    assign o_out.last      = out_last;

    // An end marker is always the final result of its byte.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.kind != KIND_UNIT |-> o_out.last)
        else $error("end marker without last");

    // A final byte always produces at least its end marker.
    a_eos_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_in.end_of_string |=> o_out.valid)
        else $error("no result after final byte");

    // With nothing pending, the decoder must take input.
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled while result buffer empty");

endmodule

>>> verif/tb_u8u16_transcode_check.sv
// Prediction and checking for the UTF-8 to UTF-16 decoder testbench.
// Watches both channel interfaces and uses u8u16_pkg for codes and masks;
// hands its mismatch count and the number of pending results to the top.
module tb_u8u16_transcode_check (
    input  logic i_clk,
    input  logic i_rst_n,
    u8u16_in_if  i_in,
    u8u16_out_if i_out,
    output int   o_mismatches,
    output int   o_outstanding
);
    import u8u16_pkg::*;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  kind;
        logic        last;
    } t_unit_result;

    t_unit_result expected_units [$];

    // Transcoder state as the block should hold it.
    logic [1:0]  cont_left;
    logic [2:0]  seq_len;
    logic [20:0] cp_bits;
    logic        err_flag;
    int          mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic report(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic clear_sequence();
        cont_left = 2'd0;
        seq_len   = 3'd0;
        cp_bits   = 21'd0;
    endtask

    // Works out the results that one byte transfer causes and queues them.
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        t_unit_result units [3];
        int           n;
        logic [4:0]   plane_full;
        n = 0;
        if (cont_left != 2'd0) begin
            if ((b & CONT_MASK) == CONT_CODE) begin
                cp_bits   = {cp_bits[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    if (seq_len == 3'd4) begin
                        // The plane field wraps, so plane 0 becomes 15.
                        plane_full = cp_bits[20:16] - 5'd1;
                        units[n] = '{SURR_HIGH + {6'd0, plane_full[3:0], cp_bits[15:10]},
                                     KIND_UNIT, 1'b0};
                        n++;
                        units[n] = '{SURR_LOW + {6'd0, cp_bits[9:0]}, KIND_UNIT, 1'b0};
                        n++;
                    end else begin
                        units[n] = '{cp_bits[15:0], KIND_UNIT, 1'b0};
                        n++;
                    end
                    clear_sequence();
                end
            end else begin
                err_flag = 1'b1;
                clear_sequence();
            end
        end else if (!b[7]) begin
            units[n] = '{{8'd0, b}, KIND_UNIT, 1'b0};
            n++;
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            cp_bits   = {16'd0, b[4:0]};
            seq_len   = 3'd2;
            cont_left = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            cp_bits   = {17'd0, b[3:0]};
            seq_len   = 3'd3;
            cont_left = 2'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            cp_bits   = {18'd0, b[2:0]};
            seq_len   = 3'd4;
            cont_left = 2'd3;
        end
        if (eos) begin
            if (cont_left != 2'd0) err_flag = 1'b1;
            units[n] = '{16'd0, err_flag ? KIND_REJECT : KIND_ACCEPT, 1'b0};
            n++;
            clear_sequence();
            err_flag = 1'b0;
        end
        if (n > 0) units[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) expected_units.push_back(units[k]);
    endtask

    always @(posedge i_clk) begin : watch
        t_unit_result want;
        if (!i_rst_n) begin
            clear_sequence();
            err_flag = 1'b0;
            expected_units.delete();
        end else begin
            // Results of a byte taken at this edge cannot leave at the same edge,
            // so the output side is checked before the new byte is predicted.
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                if (expected_units.size() == 0) begin
                    report($sformatf("unexpected result code_unit %h kind %0d last %0d",
                                     i_out.code_unit, i_out.kind, i_out.last));
                end else begin
                    want = expected_units.pop_front();
                    if (i_out.code_unit !== want.code_unit)
                        report($sformatf("code_unit got %h expected %h",
                                         i_out.code_unit, want.code_unit));
                    if (i_out.kind !== want.kind)
                        report($sformatf("kind got %0d expected %0d", i_out.kind, want.kind));
                    if (i_out.last !== want.last)
                        report($sformatf("last got %0d expected %0d", i_out.last, want.last));
                end
            end
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1)
                decode_byte(i_in.in_byte, i_in.end_of_string);
        end
        o_outstanding <= expected_units.size();
    end

endmodule

>>> verif/tb_utf8_to_utf16_decoder_top.sv
// Testbench top for utf8_to_utf16_decoder_top: clock, reset, byte strings and
// result back-pressure. Depends on the design package, both channel interfaces
// and tb_u8u16_transcode_check, which predicts and compares.
module tb_utf8_to_utf16_decoder_top;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    int         fail_count;
    int         results_outstanding;
    int         bytes_sent = 0;
    bit         idle_on = 1'b1;
    logic [8:0] string_bytes [$];

    u8u16_in_if  byte_ch ();
    u8u16_out_if unit_ch ();

    utf8_to_utf16_decoder_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (unit_ch)
    );

    tb_u8u16_transcode_check transcode_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (byte_ch),
        .i_out         (unit_ch),
        .o_mismatches  (fail_count),
        .o_outstanding (results_outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Queues a lead byte followed by n_cont continuation bytes of random content.
    task automatic add_sequence(input logic [7:0] lead, input int n_cont);
        string_bytes.push_back({1'b0, lead});
        for (int k = 0; k < n_cont; k++)
            string_bytes.push_back({3'b010, 6'($urandom_range(0, 63))});
    endtask

    // Sends every queued byte, one transfer each, with random gaps between them while idle_on is set.
    task automatic flush_string();
        logic [8:0] item;
        while (string_bytes.size() != 0) begin
            item = string_bytes.pop_front();
            if (idle_on && $urandom_range(0, 4) == 0) begin
                byte_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            byte_ch.valid         <= 1'b1;
            byte_ch.in_byte       <= item[7:0];
            byte_ch.end_of_string <= item[8];
            do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
            bytes_sent++;
        end
    endtask

    // Result side: random stalls, plain stretches and one long hold-off that
    // lets the block fill up while bytes keep coming.
    initial begin : result_sink
        int elapsed;
        int span;
        bit held;
        elapsed = 0;
        held    = 1'b0;
        unit_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!held && elapsed >= 100) begin
                unit_ch.ready <= 1'b0;
                span = 90;
                held = 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                unit_ch.ready <= 1'b0;
                span = $urandom_range(1, 13);
            end else begin
                unit_ch.ready <= 1'b1;
                span = $urandom_range(1, 20);
            end
            repeat (span) @(posedge i_clk);
            elapsed += span;
        end
    end

    initial begin : byte_source
        logic [8:0] directed_bytes [25];
        logic [8:0] last_item;
        logic [7:0] lead;
        logic [7:0] breaker;
        int         pieces;
        int         pick;
        int         need;
        // Bit 8 marks the final byte of a string.
        directed_bytes = '{
            // ASCII extremes, 2-, 3- and 4-byte forms; the pair and the end share a byte
            9'h000, 9'h07F, 9'h0C2, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
            9'h0F0, 9'h09F, 9'h098, 9'h180,
            // stray continuation, skipped leads, plane 0 wrapping to 15
            9'h080, 9'h0F8, 9'h0FF, 9'h0F0, 9'h080, 9'h080, 9'h080, 9'h141,
            // bad continuation that is swallowed, then a unit that is still emitted before the reject
            9'h0E0, 9'h041, 9'h142,
            // string that ends inside a sequence
            9'h1C3,
            // unit and accepted end from the same byte
            9'h0DF, 9'h1BF
        };

        i_rst_n               <= 1'b0;
        byte_ch.valid         <= 1'b0;
        byte_ch.in_byte       <= 8'd0;
        byte_ch.end_of_string <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[k]) string_bytes.push_back(directed_bytes[k]);
        flush_string();

        while (bytes_sent < 225) begin
            if (bytes_sent >= 190) idle_on = 1'b0;
            pieces = $urandom_range(1, 8);
            for (int p = 0; p < pieces; p++) begin
                pick = $urandom_range(0, 99);
                need = $urandom_range(1, 3);
                lead = (need == 1) ? (8'hC0 | 8'($urandom_range(0, 31))) :
                       (need == 2) ? (8'hE0 | 8'($urandom_range(0, 15))) :
                                     (8'hF0 | 8'($urandom_range(0, 7)));
                if (pick < 30) begin
                    string_bytes.push_back(9'($urandom_range(0, 127)));
                end else if (pick < 50) begin
                    add_sequence(8'hC0 | 8'($urandom_range(0, 31)), 1);
                end else if (pick < 65) begin
                    add_sequence(8'hE0 | 8'($urandom_range(0, 15)), 2);
                end else if (pick < 80) begin
                    add_sequence(8'hF0 | 8'($urandom_range(0, 7)), 3);
                end else if (pick < 85) begin
                    add_sequence(8'h80 | 8'($urandom_range(0, 63)), 0);
                end else if (pick < 89) begin
                    add_sequence(8'hF8 | 8'($urandom_range(0, 7)), 0);
                end else if (pick < 95) begin
                    // Sequence cut short by a byte that is not a continuation.
                    add_sequence(lead, $urandom_range(0, need - 1));
                    breaker = 8'($urandom_range(0, 255));
                    if (breaker[7:6] == 2'b10) breaker = breaker ^ 8'h40;
                    string_bytes.push_back({1'b0, breaker});
                end else begin
                    // String ends inside the sequence.
                    add_sequence(lead, $urandom_range(0, need - 1));
                    p = pieces;
                end
            end
            last_item = string_bytes.pop_back();
            string_bytes.push_back({1'b1, last_item[7:0]});
            flush_string();
        end

        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results_outstanding != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
